// ===== rtl/assert_macros.svh =====
// Assertion macros used by the property checker in rtl/rau_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/rau_pkg.sv =====
package rau_pkg;

    localparam int DEF_OPERAND_WIDTH = 16;
    localparam int NUM_W = 34;
    localparam int DEN_W = 32;
    localparam int OP_W = 3;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4,
        OP_CMP = 3'd5
    } op_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             den_error;
        logic             less;
        logic             equal;
        logic             greater;
    } res_t;

endpackage

// ===== rtl/rau_front.sv =====
module rau_front #(
    parameter int OperandWidth = rau_pkg::DEF_OPERAND_WIDTH,
    parameter int MagWidth = 2 * OperandWidth + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rau_pkg::OP_W-1:0]     op,
    input  logic signed [OperandWidth-1:0] a_num,
    input  logic [OperandWidth-1:0]      a_den,
    input  logic signed [OperandWidth-1:0] b_num,
    input  logic [OperandWidth-1:0]      b_den,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic                         q_direct,
    output rau_pkg::res_t                q_res,
    output logic                         q_neg,
    output logic [MagWidth-1:0]          q_mag,
    output logic [MagWidth-1:0]          q_den
);
    import rau_pkg::*;

    localparam int W = OperandWidth;
    localparam int PW = 2 * W;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_COMB} state_t;

    state_t state_reg, state_next;
    logic [OP_W-1:0] op_reg;
    logic an_neg_reg, bn_neg_reg;
    logic [W-1:0] am_reg, bm_reg, ad_reg, bd_reg;
    logic [PW-1:0] x_reg, y_reg, dd_reg;
    logic q_valid_reg, q_direct_reg, q_neg_reg;
    res_t q_res_reg;
    logic [MagWidth-1:0] q_mag_reg, q_den_reg;
    logic [MagWidth-1:0] xm, ym;
    logic [PW:0] cross_x, cross_y;

    assign in_ready = (state_reg == S_IDLE) && !q_valid_reg;
    assign q_valid = q_valid_reg;
    assign q_direct = q_direct_reg;
    assign q_res = q_res_reg;
    assign q_neg = q_neg_reg;
    assign q_mag = q_mag_reg;
    assign q_den = q_den_reg;

    assign xm = MagWidth'(x_reg);
    assign ym = MagWidth'(y_reg);
    // Signed cross values for compare.
    assign cross_x = (an_neg_reg) ? (PW+1)'(0) - {1'b0, x_reg} : {1'b0, x_reg};
    assign cross_y = (bn_neg_reg) ? (PW+1)'(0) - {1'b0, y_reg} : {1'b0, y_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid && in_ready) state_next = S_MUL;
            S_MUL: state_next = S_COMB;
            S_COMB: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            q_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_valid_reg && q_ready) q_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        op_reg <= op;
                        an_neg_reg <= a_num[W-1];
                        bn_neg_reg <= b_num[W-1];
                        am_reg <= a_num[W-1] ? W'(0) - W'(a_num) : W'(a_num);
                        bm_reg <= b_num[W-1] ? W'(0) - W'(b_num) : W'(b_num);
                        ad_reg <= a_den;
                        bd_reg <= b_den;
                    end
                end
                S_MUL: begin
                    // Magnitudes of the cross products; signs kept apart.
                    if (op_reg == OP_MUL) begin
                        x_reg <= PW'(am_reg) * PW'(bm_reg);
                        dd_reg <= PW'(ad_reg) * PW'(bd_reg);
                    end else if (op_reg == OP_DIV) begin
                        x_reg <= PW'(am_reg) * PW'(bd_reg);
                        dd_reg <= PW'(ad_reg) * PW'(bm_reg);
                    end else begin
                        x_reg <= PW'(am_reg) * PW'(bd_reg);
                        dd_reg <= PW'(ad_reg) * PW'(bd_reg);
                    end
                    y_reg <= PW'(bm_reg) * PW'(ad_reg);
                end
                S_COMB: begin
                    q_valid_reg <= 1'b1;
                    q_direct_reg <= 1'b1;
                    q_res_reg <= '{num: '0, den: DEN_W'(1), den_error: 1'b0,
                                   less: 1'b0, equal: 1'b0, greater: 1'b0};
                    q_neg_reg <= 1'b0;
                    q_mag_reg <= '0;
                    q_den_reg <= MagWidth'(1);
                    if (op_reg == OP_RED) begin
                        if (ad_reg == '0) q_res_reg.den_error <= 1'b1;
                        else if (am_reg != '0) begin
                            q_direct_reg <= 1'b0;
                            q_neg_reg <= an_neg_reg;
                            q_mag_reg <= MagWidth'(am_reg);
                            q_den_reg <= MagWidth'(ad_reg);
                        end
                    end else if (op_reg <= OP_CMP) begin
                        if (ad_reg == '0 || bd_reg == '0) begin
                            q_res_reg.den_error <= 1'b1;
                        end else if (op_reg == OP_CMP) begin
                            q_res_reg.den <= '0;
                            q_res_reg.less <= $signed(cross_x) < $signed(cross_y);
                            q_res_reg.equal <= cross_x == cross_y;
                            q_res_reg.greater <= $signed(cross_x) > $signed(cross_y);
                        end else if (op_reg == OP_DIV && bm_reg == '0) begin
                            q_res_reg.den_error <= 1'b1;
                        end else if (op_reg == OP_MUL || op_reg == OP_DIV) begin
                            if (x_reg != '0) begin
                                q_direct_reg <= 1'b0;
                                q_neg_reg <= an_neg_reg ^ bn_neg_reg;
                                q_mag_reg <= xm;
                                q_den_reg <= MagWidth'(dd_reg);
                            end
                        end else begin
                            q_direct_reg <= 1'b0;
                            q_den_reg <= MagWidth'(dd_reg);
                            if (an_neg_reg == (bn_neg_reg ^ (op_reg == OP_SUB))) begin
                                q_neg_reg <= an_neg_reg;
                                q_mag_reg <= xm + ym;
                            end else if (xm >= ym) begin
                                q_neg_reg <= an_neg_reg;
                                q_mag_reg <= xm - ym;
                            end else begin
                                q_neg_reg <= bn_neg_reg ^ (op_reg == OP_SUB);
                                q_mag_reg <= ym - xm;
                            end
                            if (xm == ym && an_neg_reg != (bn_neg_reg ^ (op_reg == OP_SUB)))
                                q_direct_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/rau_back.sv =====
module rau_back #(
    parameter int MagWidth = 2 * rau_pkg::DEF_OPERAND_WIDTH + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  logic                q_direct,
    input  rau_pkg::res_t       q_res,
    input  logic                q_neg,
    input  logic [MagWidth-1:0] q_mag,
    input  logic [MagWidth-1:0] q_den,
    output logic                out_valid,
    input  logic                out_ready,
    output rau_pkg::res_t       out_res
);
    import rau_pkg::*;

    localparam int CW = $clog2(MagWidth + 1);

    typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_OUT} state_t;

    state_t state_reg;
    logic neg_reg;
    logic [MagWidth-1:0] mag_reg, den_reg, x_reg, y_reg, g_reg;
    logic [MagWidth-1:0] quo_reg, rem_reg, dvd_reg;
    logic [CW-1:0] cnt_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic [MagWidth:0] trial;
    logic [MagWidth-1:0] quo_done;

    assign q_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;

    // One restoring division step per cycle against the divisor.
    assign trial = {rem_reg, dvd_reg[MagWidth-1]} - {1'b0, (state_reg == S_GCD) ? y_reg : g_reg};
    assign quo_done = {quo_reg[MagWidth-2:0], ~trial[MagWidth]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        if (q_direct) begin
                            out_res_reg <= q_res;
                            out_valid_reg <= 1'b1;
                        end else begin
                            neg_reg <= q_neg;
                            mag_reg <= q_mag;
                            den_reg <= q_den;
                            x_reg <= q_mag;
                            y_reg <= q_den;
                            rem_reg <= '0;
                            dvd_reg <= q_mag;
                            cnt_reg <= '0;
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    // Euclid: x mod y by long division, then swap.
                    if (y_reg == '0) begin
                        g_reg <= x_reg;
                        rem_reg <= '0;
                        dvd_reg <= mag_reg;
                        quo_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_DIVN;
                    end else begin
                        dvd_reg <= dvd_reg << 1;
                        if (!trial[MagWidth]) rem_reg <= trial[MagWidth-1:0];
                        else rem_reg <= {rem_reg[MagWidth-2:0], dvd_reg[MagWidth-1]};
                        if (cnt_reg == CW'(MagWidth - 1)) begin
                            x_reg <= y_reg;
                            y_reg <= trial[MagWidth] ?
                                {rem_reg[MagWidth-2:0], dvd_reg[MagWidth-1]} :
                                trial[MagWidth-1:0];
                            dvd_reg <= y_reg;
                            rem_reg <= '0;
                            cnt_reg <= '0;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_DIVN, S_DIVD: begin
                    dvd_reg <= dvd_reg << 1;
                    quo_reg <= quo_done;
                    if (!trial[MagWidth]) rem_reg <= trial[MagWidth-1:0];
                    else rem_reg <= {rem_reg[MagWidth-2:0], dvd_reg[MagWidth-1]};
                    if (cnt_reg == CW'(MagWidth - 1)) begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        if (state_reg == S_DIVN) begin
                            mag_reg <= quo_done;
                            dvd_reg <= den_reg;
                            state_reg <= S_DIVD;
                        end else begin
                            den_reg <= quo_done;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    out_res_reg.num <= neg_reg ? NUM_W'(0) - NUM_W'(mag_reg) : NUM_W'(mag_reg);
                    out_res_reg.den <= DEN_W'(den_reg);
                    out_res_reg.den_error <= 1'b0;
                    out_res_reg.less <= 1'b0;
                    out_res_reg.equal <= 1'b0;
                    out_res_reg.greater <= 1'b0;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: each input word carries an op and two fractions,
// and one result word follows with the reduced fraction, or the compare or error flags.
// The front stage forms the cross products in a multiply state and a
// combine state and hands the job on; the back stage runs Euclid's algorithm
// by bit-serial long division and then divides the numerator and the
// denominator by the GCD in the same way; compare, error and zero results skip it.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // op, a_num, a_den, b_num, b_den from bit 0 up, zero padded.
    input  logic [((rau_pkg::OP_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // res_num, res_den from bit 0 up, zero padded.
    output logic [71:0]                 m_tdata,
    // den_error, less, equal, greater from bit 0 up.
    output logic [3:0]                  m_tuser
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam int MW = 2 * W + 1;

    logic q_valid, q_ready, q_direct, q_neg;
    res_t q_res, out_res;
    logic [MW-1:0] q_mag, q_den;

    rau_front #(.OperandWidth(W), .MagWidth(MW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tdata[OP_W-1:0]),
        .a_num(s_tdata[OP_W + W - 1:OP_W]),
        .a_den(s_tdata[OP_W + 2*W - 1:OP_W + W]),
        .b_num(s_tdata[OP_W + 3*W - 1:OP_W + 2*W]),
        .b_den(s_tdata[OP_W + 4*W - 1:OP_W + 3*W]),
        .q_valid(q_valid), .q_ready(q_ready), .q_direct(q_direct),
        .q_res(q_res), .q_neg(q_neg), .q_mag(q_mag), .q_den(q_den)
    );

    rau_back #(.MagWidth(MW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_direct(q_direct),
        .q_res(q_res), .q_neg(q_neg), .q_mag(q_mag), .q_den(q_den),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(out_res)
    );

    assign m_tdata = {6'd0, out_res.den, out_res.num};
    assign m_tuser = {out_res.greater, out_res.equal, out_res.less, out_res.den_error};

endmodule

// ===== rtl/rau_checker.sv =====
`include "assert_macros.svh"

module rau_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [3:0] m_tuser
);
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CHK_IMPL(a_flags, aclk, aresetn, m_tvalid, $countones(m_tuser[3:1]) <= 1)
    `CHK_IMPL(a_err, aclk, aresetn, m_tvalid && m_tuser[0], m_tuser[3:1] == 3'd0)
    `CHK_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind rational_arithmetic_unit_top rau_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);

// ===== dv/rau_checker.sv =====
`timescale 1ns / 100ps

module rau_checker #(
    parameter int OPERAND_WIDTH = 16,
    parameter int S_W = 72
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [S_W-1:0] s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [71:0]    m_tdata,
    input  logic [3:0]     m_tuser,
    output int             fail_count,
    output int             pending
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    res_t expected_results[$];

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic res_t make_fraction(bit neg, longint unsigned mag,
                                           longint unsigned den, bit err);
        res_t r;
        longint unsigned g;
        longint unsigned n;
        longint unsigned d;
        n = 0;
        d = 1;
        if (!err && mag != 0 && den != 0) begin
            g = euclid(mag, den);
            mag = mag / g;
            d = den / g;
            n = neg ? -mag : mag;
        end
        if (err || den == 0) begin
            n = 0;
            d = 1;
            err = 1;
        end
        r = '0;
        r.num = n[NUM_W-1:0];
        r.den = d[DEN_W-1:0];
        r.den_error = err;
        return r;
    endfunction

    function automatic longint unsigned mag_of(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function automatic res_t compute_fraction(logic [S_W-1:0] w);
        logic [2:0] op;
        longint an;
        longint bn;
        longint unsigned ad;
        longint unsigned bd;
        longint x;
        longint y;
        longint unsigned xm;
        longint unsigned ym;
        bit xn;
        bit yn;
        res_t r;
        op = w[2:0];
        an = longint'($signed(w[3 +: W]));
        ad = w[3 + W +: W];
        bn = longint'($signed(w[3 + 2 * W +: W]));
        bd = w[3 + 3 * W +: W];
        if (op > OP_CMP) return make_fraction(0, 0, 1, 0);
        if (op == OP_RED) return make_fraction(an < 0, mag_of(an), ad, ad == 0);
        if (ad == 0 || bd == 0) return make_fraction(0, 0, 1, 1);
        x = an * longint'(bd);
        y = bn * longint'(ad);
        case (op_t'(op))
            OP_ADD, OP_SUB: begin
                xn = x < 0;
                yn = (op == OP_ADD) ? (y < 0) : (y > 0);
                xm = mag_of(x);
                ym = mag_of(y);
                if (xn == yn) r = make_fraction(xn, xm + ym, ad * bd, 0);
                else if (xm >= ym) r = make_fraction(xn, xm - ym, ad * bd, 0);
                else r = make_fraction(yn, ym - xm, ad * bd, 0);
            end
            OP_MUL: r = make_fraction((an < 0) != (bn < 0), mag_of(an) * mag_of(bn),
                                      ad * bd, 0);
            OP_DIV: begin
                if (bn == 0) r = make_fraction(0, 0, 1, 1);
                else r = make_fraction((an < 0) != (bn < 0), mag_of(an) * bd,
                                       ad * mag_of(bn), 0);
            end
            default: begin
                r = '0;
                r.less = x < y;
                r.equal = x == y;
                r.greater = x > y;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = expected_results.size();

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(compute_fraction(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected", $realtime);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[33:0] !== want.num) report_mismatch("res_num", m_tdata[33:0], want.num);
                if (m_tdata[65:34] !== want.den) report_mismatch("res_den", m_tdata[65:34], want.den);
                if (m_tdata[71:66] !== 6'd0) report_mismatch("padding", m_tdata[71:66], 0);
                if (m_tuser[0] !== want.den_error)
                    report_mismatch("den_error", m_tuser[0], want.den_error);
                if (m_tuser[1] !== want.less) report_mismatch("less", m_tuser[1], want.less);
                if (m_tuser[2] !== want.equal) report_mismatch("equal", m_tuser[2], want.equal);
                if (m_tuser[3] !== want.greater)
                    report_mismatch("greater", m_tuser[3], want.greater);
            end
        end
    end

endmodule

// ===== dv/tb_rational_arithmetic_unit_top.sv =====
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_top;
    import rau_pkg::*;

    localparam int W = 16;
    localparam int S_W = ((OP_W + 4 * W + 7) / 8) * 8;
    localparam int N_RANDOM = 1730;

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           s_tvalid = 0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 0;
    logic [71:0]    m_tdata;
    logic [3:0]     m_tuser;
    int             fail_count;
    int             pending;
    bit             calm = 0;

    always #5 aclk = ~aclk;

    rational_arithmetic_unit_top #(.OPERAND_WIDTH(W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rau_checker #(.OPERAND_WIDTH(W), .S_W(S_W)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 22);
    end

    task automatic send_word(logic [2:0] op, logic [W-1:0] an, logic [W-1:0] ad,
                             logic [W-1:0] bn, logic [W-1:0] bd);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= S_W'({bd, bn, ad, an, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(5))
            0: return W'($urandom_range(3));
            1: return {1'b1, {(W - 1){1'b0}}};
            2: return {1'b0, {(W - 1){1'b1}}};
            3: return '1;
            4: return W'($urandom_range(40)) * W'($urandom_range(12));
            default: return W'($urandom);
        endcase
    endfunction

    initial begin
        logic [W-1:0] nmin;
        logic [W-1:0] nmax;
        logic [2:0] op;
        logic [W-1:0] ad;
        logic [W-1:0] bd;
        nmin = {1'b1, {(W - 1){1'b0}}};
        nmax = {1'b0, {(W - 1){1'b1}}};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        send_word(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_word(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_word(OP_MUL, nmin, 16'd1, nmin, 16'd1);
        send_word(OP_DIV, nmax, 16'hffff, nmin, 16'hffff);
        send_word(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
        send_word(OP_RED, -16'sd6, 16'd4, 16'd0, 16'd0);
        send_word(OP_RED, 16'd3, 16'd0, 16'd1, 16'd1);
        send_word(OP_RED, 16'd0, 16'd9, 16'd1, 16'd1);
        send_word(OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
        send_word(OP_CMP, -16'sd1, 16'd2, 16'd1, 16'd3);
        send_word(OP_CMP, nmax, 16'hffff, nmin, 16'd1);
        send_word(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
        send_word(OP_CMP, 16'd1, 16'd1, 16'd1, 16'd0);
        send_word(OP_MUL, nmin, 16'hffff, nmax, 16'hffff);
        send_word(OP_SUB, nmin, 16'hfffe, nmax, 16'hffff);
        send_word(3'd6, 16'd1, 16'd1, 16'd1, 16'd1);
        send_word(3'd7, '1, '1, '1, '1);
        calm = 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 200) calm = 0;
            op = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            ad = pick_value();
            bd = pick_value();
            if ($urandom_range(9) != 0) begin
                if (ad == 0) ad = 1;
                if (bd == 0) bd = 1;
            end
            send_word(op, pick_value(), ad, pick_value(), bd);
        end
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("Verification failed");
        $finish;
    end

endmodule
